>>> hdl/integer_to_base_digits_unit_assert.svh
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef INTEGER_TO_BASE_DIGITS_UNIT_ASSERT_SVH
`define INTEGER_TO_BASE_DIGITS_UNIT_ASSERT_SVH

// same-cycle implication
`define ITBD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITBD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/itbd_pkg.sv
`default_nettype none

package itbd_pkg;

  localparam int unsigned MAX_SYMBOLS = 16;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned STEP_BITS   = 8;

  localparam logic [7:0] MINUS_SIGN = 8'h2D;
  localparam logic [7:0] PLUS_SIGN  = 8'h2B;

  typedef enum logic [1:0] {
    REG_SYMBOL_COUNT = 2'd0,
    REG_SYMBOLS_LOW  = 2'd1,
    REG_SYMBOLS_HIGH = 2'd2
  } reg_index_t;

  localparam logic [4:0]  SYMBOL_COUNT_RESET = 5'd10;
  localparam logic [63:0] SYMBOLS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [63:0] SYMBOLS_HIGH_RESET = 64'h0000000000003938;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_CHECK   = 6'b000010,
    ST_DIV     = 6'b000100,
    ST_SIGN    = 6'b001000,
    ST_EMIT_RD = 6'b010000,
    ST_EMIT_WR = 6'b100000
  } state_t;

  // symbol lookup in the 16-byte alphabet, symbol 0 in the lowest byte
  function automatic logic [7:0] sym_sel(input logic [127:0] tab,
                                         input logic [DIGIT_W-1:0] idx);
    return tab[{idx, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

>>> hdl/integer_to_base_digits_unit.sv
// steps: a check state, then the shared radix divider once per digit, a byte of the
//   magnitude at a time (8 quotient bits per cycle), then a read and a write state per
//   digit, and a sign state first for a negative value; a zero prints symbol 0 from
//   the check state and a bad alphabet drops the value; one value at a time, in idle
// reset (rst, synchronous): alphabet back to decimal "0123456789", sequencer idle,
//   output register empty
`default_nettype none

`include "integer_to_base_digits_unit_assert.svh"

module integer_to_base_digits_unit #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  // value
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [((VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // character
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [7:0]                         m_axis_tdata,
  output logic                               m_axis_tlast,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [1:0]                         cfg_index,
  input  wire  [63:0]                        cfg_data
);
  import itbd_pkg::*;

  localparam int unsigned MAG_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned NBYTES = MAG_W / STEP_BITS;
  localparam int unsigned BCNT_W = (NBYTES > 1) ? $clog2(NBYTES) : 1;
  localparam int unsigned ADDR_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [4:0]   symbol_count;
  logic [63:0]  symbols_low;
  logic [63:0]  symbols_high;
  logic         alpha_ok;
  logic         alpha_ok_next;
  logic [127:0] sym_tab;

  state_t              state;
  logic                neg;
  logic                is_zero;
  logic [MAG_W-1:0]    mag;
  logic [4:0]          rem;
  logic [BCNT_W-1:0]   byte_cnt;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   ptr;

  logic [DIGIT_W-1:0]  digit_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]  mem_q;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] raw_mag;
  logic [STEP_BITS-1:0]  q_byte;
  logic [4:0]            rem_next;
  logic [MAG_W-1:0]      mag_next;
  logic                  last_byte;
  logic                  div_done;
  logic                  out_free;
  logic                  load_out;
  logic [7:0]            load_char;
  logic                  load_last;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign sym_tab       = {symbols_high, symbols_low};
  assign raw           = s_axis_tdata[VALUE_BITS-1:0];
  assign raw_mag       = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= SYMBOL_COUNT_RESET;
      symbols_low  <= SYMBOLS_LOW_RESET;
      symbols_high <= SYMBOLS_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYMBOL_COUNT: symbol_count <= cfg_data[4:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // alphabet check: count in range, no sign symbols, pairwise distinct
  always_comb begin
    alpha_ok_next = (symbol_count >= 5'd2) && (symbol_count <= 5'(MAX_SYMBOLS));
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < symbol_count) begin
        if (sym_tab[i*8 +: 8] == MINUS_SIGN || sym_tab[i*8 +: 8] == PLUS_SIGN) begin
          alpha_ok_next = 1'b0;
        end
        for (int j = i + 1; j < 16; j++) begin
          if (5'(j) < symbol_count && sym_tab[j*8 +: 8] == sym_tab[i*8 +: 8]) begin
            alpha_ok_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_ok <= 1'b0;
    end else begin
      alpha_ok <= alpha_ok_next;
    end
  end

  // one byte of long division by the radix, msb first
  always_comb begin
    logic [5:0] t;
    logic [4:0] r;
    r      = rem;
    q_byte = '0;
    for (int k = STEP_BITS - 1; k >= 0; k--) begin
      t = {r, mag[MAG_W-STEP_BITS+k]};
      if (t >= {1'b0, symbol_count}) begin
        t         = t - {1'b0, symbol_count};
        q_byte[k] = 1'b1;
      end
      r = t[4:0];
    end
    rem_next = r;
  end

  assign mag_next  = {mag[MAG_W-STEP_BITS-1:0], q_byte};
  assign last_byte = (byte_cnt == BCNT_W'(NBYTES - 1));
  assign div_done  = (state == ST_DIV) && last_byte;

  always_ff @(posedge clk) begin
    if (div_done) begin
      digit_mem[wr_addr] <= rem_next[DIGIT_W-1:0];
    end
    mem_q <= digit_mem[ptr];
  end

  always_comb begin
    load_out  = 1'b0;
    load_char = sym_sel(sym_tab, mem_q);
    load_last = (ptr == '0);
    case (state)
      ST_CHECK: begin
        load_out  = is_zero && out_free;
        load_char = symbols_low[7:0];
        load_last = 1'b1;
      end
      ST_SIGN: begin
        load_out  = out_free;
        load_char = MINUS_SIGN;
        load_last = 1'b0;
      end
      ST_EMIT_WR: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      byte_cnt <= '0;
      wr_addr  <= '0;
      ptr      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state   <= ST_CHECK;
            neg     <= raw[VALUE_BITS-1];
            is_zero <= (raw == '0);
            mag     <= MAG_W'(raw_mag);
          end
        end
        ST_CHECK: begin
          byte_cnt <= '0;
          wr_addr  <= '0;
          rem      <= '0;
          if (is_zero) begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else if (alpha_ok) begin
            state <= ST_DIV;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          mag <= mag_next;
          if (last_byte) begin
            byte_cnt <= '0;
            rem      <= '0;
            wr_addr  <= wr_addr + 1'b1;
            if (mag_next == '0) begin
              ptr   <= wr_addr;
              state <= neg ? ST_SIGN : ST_EMIT_RD;
            end
          end else begin
            byte_cnt <= byte_cnt + 1'b1;
            rem      <= rem_next;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            state <= ST_EMIT_RD;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_WR;
        end
        ST_EMIT_WR: begin
          if (out_free) begin
            if (ptr == '0) begin
              state <= ST_IDLE;
            end else begin
              ptr   <= ptr - 1'b1;
              state <= ST_EMIT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register, holds a beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= load_char;
      m_axis_tlast <= load_last;
    end
  end

  `ITBD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "ready right after an accepted value")
  `ITBD_ASSERT_NOW(a_digit_below_radix, div_done, rem_next < symbol_count,
    "division remainder not below the radix")
  `ITBD_ASSERT_NOW(a_read_digit_valid, state == ST_EMIT_WR, {1'b0, mem_q} < symbol_count,
    "stored digit not below the radix")
  `ITBD_ASSERT_NOW(a_sign_not_last, m_axis_tvalid && m_axis_tdata == MINUS_SIGN
    && state == ST_EMIT_RD, !m_axis_tlast, "minus sign marked as last")

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itbd_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 400;

  // index 3 maps to no register
  localparam logic [1:0] REG_OUT_OF_RANGE = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] character
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // local copy of the alphabet registers
  logic [4:0]  alpha_count = SYMBOL_COUNT_RESET;
  logic [63:0] alpha_low   = SYMBOLS_LOW_RESET;
  logic [63:0] alpha_high  = SYMBOLS_HIGH_RESET;

  char_beat_t  pending_chars[$];

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int          errors        = 0;
  int          values_sent   = 0;
  int          chars_seen    = 0;
  int          alphabets_tried = 0;

  integer_to_base_digits_unit #(
    .VALUE_BITS(32)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] alphabet_symbol(input int unsigned idx);
    logic [127:0] tab;
    tab = {alpha_high, alpha_low};
    return tab[8*idx +: 8];
  endfunction

  function automatic bit alphabet_usable();
    int unsigned n;
    n = alpha_count;
    if (n < 2 || n > MAX_SYMBOLS) return 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (alphabet_symbol(i) == MINUS_SIGN || alphabet_symbol(i) == PLUS_SIGN) return 1'b0;
      for (int unsigned j = i + 1; j < n; j++)
        if (alphabet_symbol(j) == alphabet_symbol(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue up the characters one value should produce
  function automatic void render_value(input logic [31:0] value);
    logic [31:0] mag;
    logic [31:0] radix;
    int unsigned digits[33];
    int          nd;
    nd = 0;
    if (value == '0) begin
      pending_chars.push_back(char_beat_t'{ch: alphabet_symbol(0), last: 1'b1});
      return;
    end
    if (!alphabet_usable()) return;
    // unsigned negate also covers the most negative value
    mag = value[31] ? -value : value;
    radix = 32'(alpha_count);
    while (mag != 0) begin
      digits[nd] = int'(mag % radix);
      mag = mag / radix;
      nd++;
    end
    if (value[31]) pending_chars.push_back(char_beat_t'{ch: MINUS_SIGN, last: 1'b0});
    for (int k = nd - 1; k >= 0; k--)
      pending_chars.push_back(char_beat_t'{ch: alphabet_symbol(digits[k]), last: (k == 0)});
  endfunction

  always @(posedge clk) begin : check_chars
    char_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      chars_seen++;
      if (pending_chars.size() == 0) begin
        $display("%0t ns: expected no character, got 0x%02h last %0b",
                 $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.ch) begin
          $display("%0t ns: character expected 0x%02h, got 0x%02h",
                   $time, want.ch, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t ns: last expected %0b, got %0b", $time, want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles, %0d characters outstanding",
               $time, WATCHDOG_LIMIT, pending_chars.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // called and returns at a falling edge; tvalid stays up for a back-to-back beat
  task automatic send_value(input logic [31:0] value);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    render_value(value);
    values_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (index)
      REG_SYMBOL_COUNT: alpha_count = data[4:0];
      REG_SYMBOLS_LOW:  alpha_low   = data;
      REG_SYMBOLS_HIGH: alpha_high  = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_alphabet(input logic [4:0] count, input logic [63:0] low,
                               input logic [63:0] high);
    write_reg(REG_SYMBOL_COUNT, 64'(count));
    write_reg(REG_SYMBOLS_LOW, low);
    write_reg(REG_SYMBOLS_HIGH, high);
  endtask

  // drain all characters, then give a value with no output time to finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_decimal_default();
    send_value(0);
    send_value(7);
    send_value(-7);
    send_value(10);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(-1000000);
    settle();
  endtask

  task automatic test_radix_bounds();
    // count keeps only its low five bits
    write_reg(REG_SYMBOL_COUNT, 64'hFFFF_FFFF_FFFF_FFE2);
    write_reg(REG_SYMBOLS_LOW, 64'h0000_0000_0000_3130);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(5);
    settle();
    // zero and all-ones bytes are plain symbols
    load_alphabet(16, 64'hFF06_0504_0302_0100, 64'h6665_6463_6261_3938);
    send_value(-1);
    send_value(32'hDEAD_BEEF);
    send_value(0);
    send_value(15);
    settle();
  endtask

  task automatic test_invalid_alphabets();
    load_alphabet(0, SYMBOLS_LOW_RESET, SYMBOLS_HIGH_RESET);
    send_value(0);
    send_value(5);
    settle();
    write_reg(REG_SYMBOL_COUNT, 64'd1);
    send_value(-3);
    settle();
    write_reg(REG_SYMBOL_COUNT, 64'(MAX_SYMBOLS + 1));
    send_value(1);
    settle();
    write_reg(REG_SYMBOL_COUNT, 64'd31);
    send_value(0);
    send_value(32'h8000_0000);
    settle();
    // plus sign among the digits
    load_alphabet(10, 64'h3736_3534_2B32_3130, SYMBOLS_HIGH_RESET);
    send_value(12);
    settle();
    // minus sign as symbol 0: zero still prints it
    write_reg(REG_SYMBOLS_LOW, 64'h3736_3534_3332_312D);
    send_value(0);
    send_value(12);
    settle();
    // last symbol repeats the first
    load_alphabet(16, 64'h3736_3534_3332_3130, 64'h3046_4544_4342_3938);
    send_value(-5);
    settle();
    load_alphabet(SYMBOL_COUNT_RESET, SYMBOLS_LOW_RESET, SYMBOLS_HIGH_RESET);
    write_reg(REG_OUT_OF_RANGE, {$urandom, $urandom});
    send_value(42);
    settle();
  endtask

  task automatic test_random_alphabets(input int unsigned src_pct, input int unsigned snk_pct,
                                       input int unsigned rounds, input int unsigned per_round);
    logic [7:0]  syms[16];
    logic [63:0] low;
    logic [63:0] high;
    logic [31:0] value;
    int unsigned count;
    int unsigned a;
    int unsigned b;
    bit          clash;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    repeat (rounds) begin
      for (int i = 0; i < 16; i++) begin
        do begin
          syms[i] = 8'($urandom);
          clash = (syms[i] == MINUS_SIGN) || (syms[i] == PLUS_SIGN);
          for (int j = 0; j < i; j++)
            if (syms[j] == syms[i]) clash = 1'b1;
        end while (clash);
      end
      case ($urandom_range(7))
        0: count = 2;
        1: count = MAX_SYMBOLS;
        default: count = $urandom_range(2, MAX_SYMBOLS);
      endcase
      // one alphabet in five gets broken
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(2))
          0: count = $urandom_range(1) ? $urandom_range(1) : $urandom_range(MAX_SYMBOLS + 1, 31);
          1: syms[$urandom_range(count - 1)] = $urandom_range(1) ? MINUS_SIGN : PLUS_SIGN;
          default: begin
            a = $urandom_range(count - 2);
            b = $urandom_range(a + 1, count - 1);
            syms[b] = syms[a];
          end
        endcase
      end
      for (int i = 0; i < 8; i++) begin
        low[8*i +: 8]  = syms[i];
        high[8*i +: 8] = syms[i+8];
      end
      load_alphabet(5'(count), low, high);
      alphabets_tried++;
      repeat (per_round) begin
        case ($urandom_range(9))
          0: value = '0;
          1: value = 32'h8000_0000;
          2: value = 32'h7FFF_FFFF;
          3: value = $urandom_range(200) - 100;
          4: value = {($urandom_range(1) ? 28'hFFF_FFFF : 28'h000_0000), 4'($urandom)};
          default: value = $urandom;
        endcase
        send_value(value);
      end
      settle();
    end
  endtask

  // radix 2 gives long strings; a held output backs the block up into its input
  task automatic test_output_hold();
    load_alphabet(2, 64'h0000_0000_0000_3130, 64'h0);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req = HOLD_CYCLES;
    repeat (12) send_value($urandom);
    settle();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_decimal_default();
    test_radix_bounds();
    test_invalid_alphabets();
    test_random_alphabets(24, 64, 5, 28);
    test_random_alphabets(64, 24, 5, 28);
    test_random_alphabets(0, 0, 5, 28);
    test_output_hold();
    $display("converted %0d values into %0d characters over %0d random alphabets",
             values_sent, chars_seen, alphabets_tried);
    $display("radix 2 to 16, broken alphabets, stalls on both sides, %0d-cycle output hold",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
